### design/pcf_pkg.sv
// ---------------------------------------------------------------------------
// pcf_pkg
// Shared widths, register indexes, sequencer states, divider command and
// status words, and saturation helpers for the two-form PID controller.
// ---------------------------------------------------------------------------
package pcf_pkg;

    localparam int DATA_W    = 32;
    localparam int PROD_W    = 64;
    localparam int Q_SHIFT   = 16;
    localparam int DIVD_W    = 47;
    localparam int DIVS_W    = 32;
    localparam int CNT_W     = $clog2(DIVD_W + 1);
    localparam int LIM_W     = 31;
    localparam int RATE_W    = 16;
    localparam int IINC_W    = 48;
    localparam int INT_W     = IINC_W + 1;
    localparam int SUM_W     = DATA_W + 3;
    localparam int CFG_IDX_W = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_P_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_I_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_D_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 3'd5;

    // Controller forms
    localparam logic MODE_POS = 1'b0;
    localparam logic MODE_VEL = 1'b1;

    // Integral clamp is 2*limit/5, taken as (2*limit * CLAMP_RECIP) >> CLAMP_SHIFT,
    // which is exact for any 32-bit unsigned operand
    localparam logic [DIVS_W-1:0] CLAMP_RECIP = 32'hCCCC_CCCD;
    localparam int                CLAMP_SHIFT = 34;

    localparam logic [LIM_W-1:0]  LIMIT_RESET = 31'd65536;
    localparam logic [RATE_W-1:0] RATE_RESET  = 16'd100;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_MUL_A = 10'b00_0000_0010,
        ST_MUL_B = 10'b00_0000_0100,
        ST_MUL_C = 10'b00_0000_1000,
        ST_MUL_D = 10'b00_0001_0000,
        ST_DIV_P = 10'b00_0010_0000,
        ST_DIV_D = 10'b00_0100_0000,
        ST_INTEG = 10'b00_1000_0000,
        ST_SUM   = 10'b01_0000_0000,
        ST_CLAMP = 10'b10_0000_0000
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIVD_W-1:0] quot;
    } div_stat_t;

    // Saturate a wide signed value to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < 64'shFFFF_FFFF_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    // Apply a sign to an unsigned quotient and saturate to 32 bits
    function automatic logic signed [DATA_W-1:0] sat_mag(input logic [DIVD_W-1:0] q,
                                                          input logic neg);
        logic signed [DATA_W-1:0] r;
        if (!neg) begin
            if (q > 47'h0000_7FFF_FFFF)
                r = 32'sh7FFF_FFFF;
            else
                r = q[DATA_W-1:0];
        end
        else begin
            if (q > 47'h0000_8000_0000)
                r = 32'sh8000_0000;
            else
                r = -q[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

### design/pcf_div.sv
// ---------------------------------------------------------------------------
// pcf_div
// Restoring unsigned divider, one quotient bit per cycle. A start word loads
// dividend and divisor; done pulses for one cycle with the quotient valid.
// ---------------------------------------------------------------------------
module pcf_div (
    input  logic                clk,
    input  logic                rst_n,
    input  pcf_pkg::div_cmd_t   cmd,
    output pcf_pkg::div_stat_t  stat
);
    import pcf_pkg::*;

    logic [DIVD_W-1:0] quot_reg, quot_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVS_W-1:0] divisor_reg, divisor_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;

    // One shift-and-subtract step per cycle
    always_comb
    begin
        trial        = {rem_reg, quot_reg[DIVD_W-1]};
        diff         = trial - {1'b0, divisor_reg};
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (cmd.start)
        begin
            quot_next    = cmd.dividend;
            rem_next     = '0;
            divisor_next = cmd.divisor;
            cnt_next     = CNT_W'(DIVD_W);
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor_reg})
            begin
                rem_next  = diff[DIVS_W-1:0];
                quot_next = {quot_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[DIVS_W-1:0];
                quot_next = {quot_reg[DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Hold operands
    always_ff @(posedge clk)
    begin
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.quot = quot_reg;

endmodule

### design/pid_controller_two_form.sv
// ---------------------------------------------------------------------------
// pid_controller_two_form
// Q16.16 PID controller, positional or velocity form, one error word in and
// one word of drive and P, I, D terms out. A small sequencer runs one shared
// 33x33 multiplier and one 47-step restoring divider. In positional mode a
// word goes through three gain multiplies, a reciprocal multiply for the
// 0.4*limit integral clamp, clamp and sum; in velocity mode it goes through
// two divisions, by rate and by rate squared. Input stall is high from
// acceptance until the result moves into the output register; the result
// then waits there while the next word is taken in. Write configuration
// only while no word is in flight; a write takes effect at once.
// ---------------------------------------------------------------------------
module pid_controller_two_form (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [pcf_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [pcf_pkg::DATA_W-1:0]             cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [pcf_pkg::DATA_W-1:0]      error,
    input  logic                                   clear,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [pcf_pkg::DATA_W-1:0]      drive,
    output logic signed [pcf_pkg::DATA_W-1:0]      p_term,
    output logic signed [pcf_pkg::DATA_W-1:0]      i_term,
    output logic signed [pcf_pkg::DATA_W-1:0]      d_term
);
    import pcf_pkg::*;

    // Configuration
    logic                      mode_reg;
    logic signed [DATA_W-1:0]  p_gain_reg, i_gain_reg, d_gain_reg;
    logic [LIM_W-1:0]          limit_reg;
    logic [RATE_W-1:0]         rate_reg;

    // Controller state
    logic signed [DATA_W-1:0]  integral_reg, integral_next;
    logic signed [DATA_W-1:0]  last_err_reg, last_err_next;
    logic signed [DATA_W-1:0]  older_err_reg, older_err_next;
    logic signed [DATA_W-1:0]  last_drive_reg, last_drive_next;

    // Sequencer and output slot
    state_t                    state_reg, state_next;
    logic                      out_valid_reg, out_valid_next;

    // Work registers
    logic signed [DATA_W-1:0]  err_reg, err_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [DATA_W-1:0]  p_reg, p_next, i_reg, i_next, d_reg, d_next;
    logic signed [IINC_W-1:0]  iinc_reg, iinc_next;
    logic [LIM_W-1:0]          lim40_reg, lim40_next;
    logic [DIVS_W-1:0]         rr_reg, rr_next;
    logic                      neg_reg, neg_next;
    logic signed [DATA_W-1:0]  drive_reg, drive_next;
    logic signed [DATA_W-1:0]  p_out_reg, p_out_next;
    logic signed [DATA_W-1:0]  i_out_reg, i_out_next;
    logic signed [DATA_W-1:0]  d_out_reg, d_out_next;

    // Datapath
    logic                      in_acc;
    logic                      slot_free;
    logic [RATE_W-1:0]         rate_eff;
    logic signed [DATA_W:0]    diff1;
    logic signed [DATA_W+1:0]  dd_wide;
    logic signed [DATA_W-1:0]  dd;
    logic signed [DATA_W:0]    mul_a, mul_b;
    logic signed [2*DATA_W+1:0] mul_p;
    logic signed [PROD_W-1:0]  prod_q;
    logic [PROD_W-1:0]         prod_abs;
    logic signed [INT_W-1:0]   int_sum, int_hi;
    logic signed [DATA_W-1:0]  int_clamped;
    logic signed [SUM_W-1:0]   drive_sum, lim_s;
    logic signed [DATA_W-1:0]  drive_clamped;
    div_cmd_t                  div_cmd;
    div_stat_t                 div_stat;

    pcf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .stat  (div_stat)
    );

    assign in_acc    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign rate_eff  = (rate_reg == '0) ? RATE_W'(1) : rate_reg;

    // Form first and second differences of the error
    assign diff1   = 33'(err_reg) - 33'(last_err_reg);
    assign dd_wide = 34'(diff1) - (34'(last_err_reg) - 34'(older_err_reg));
    assign dd      = sat32(64'(dd_wide));

    // Round the product toward minus infinity and take its magnitude
    assign prod_q   = prod_reg >>> Q_SHIFT;
    assign prod_abs = prod_reg[PROD_W-1] ? (~prod_reg + 64'sd1) : prod_reg;

    // Select multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_A:
            begin
                mul_a = (mode_reg == MODE_POS) ? 33'(err_reg) : diff1;
                mul_b = 33'(p_gain_reg);
            end
            ST_MUL_B:
            begin
                mul_a = 33'(err_reg);
                mul_b = 33'(i_gain_reg);
            end
            ST_MUL_C:
            begin
                if (mode_reg == MODE_POS)
                begin
                    mul_a = diff1;
                    mul_b = 33'(d_gain_reg);
                end
                else
                begin
                    mul_a = $signed({17'b0, rate_eff});
                    mul_b = $signed({17'b0, rate_eff});
                end
            end
            ST_MUL_D:
            begin
                if (mode_reg == MODE_POS)
                begin
                    mul_a = $signed({1'b0, limit_reg, 1'b0});
                    mul_b = $signed({1'b0, CLAMP_RECIP});
                end
                else
                begin
                    mul_a = 33'(dd);
                    mul_b = 33'(d_gain_reg);
                end
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Clamp the integral to 0.4 times the limit
    assign int_sum     = 49'(integral_reg) + 49'(iinc_reg);
    assign int_hi      = $signed({18'b0, lim40_reg});
    assign int_clamped = (int_sum > int_hi)  ? DATA_W'(int_hi) :
                         (int_sum < -int_hi) ? DATA_W'(-int_hi) :
                                               DATA_W'(int_sum);

    // Sum the terms and clamp to the output limit
    assign lim_s     = $signed({4'b0, limit_reg});
    assign drive_sum = 35'(p_reg) + 35'(i_reg) + 35'(d_reg) +
                       ((mode_reg == MODE_VEL) ? 35'(last_drive_reg) : 35'sd0);
    assign drive_clamped = (drive_sum > lim_s)  ? DATA_W'(lim_s) :
                           (drive_sum < -lim_s) ? DATA_W'(-lim_s) :
                                                  DATA_W'(drive_sum);

    // Sequence one word through the shared units
    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && out_stall;
        integral_next   = integral_reg;
        last_err_next   = last_err_reg;
        older_err_next  = older_err_reg;
        last_drive_next = last_drive_reg;
        err_next        = err_reg;
        prod_next       = prod_reg;
        p_next          = p_reg;
        i_next          = i_reg;
        d_next          = d_reg;
        iinc_next       = iinc_reg;
        lim40_next      = lim40_reg;
        rr_next         = rr_reg;
        neg_next        = neg_reg;
        drive_next      = drive_reg;
        p_out_next      = p_out_reg;
        i_out_next      = i_out_reg;
        d_out_next      = d_out_reg;
        div_cmd.start    = 1'b0;
        div_cmd.dividend = prod_abs[DIVD_W+Q_SHIFT-1:Q_SHIFT];
        div_cmd.divisor  = {16'b0, rate_eff};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    err_next = error;
                    if (clear)
                    begin
                        integral_next = '0;
                        last_err_next = '0;
                    end
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A:
            begin
                prod_next  = mul_p[PROD_W-1:0];
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                p_next    = sat32(prod_q);
                prod_next = mul_p[PROD_W-1:0];
                if (mode_reg == MODE_VEL)
                begin
                    div_cmd.start = 1'b1;
                    neg_next      = prod_reg[PROD_W-1];
                end
                state_next = ST_MUL_C;
            end
            ST_MUL_C:
            begin
                iinc_next  = IINC_W'(prod_q);
                i_next     = sat32(prod_q);
                prod_next  = mul_p[PROD_W-1:0];
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                prod_next = mul_p[PROD_W-1:0];
                if (mode_reg == MODE_POS)
                begin
                    d_next     = sat32(prod_q);
                    state_next = ST_CLAMP;
                end
                else
                begin
                    rr_next    = prod_reg[DIVS_W-1:0];
                    state_next = ST_DIV_P;
                end
            end
            ST_CLAMP:
            begin
                // Take 2*limit/5 from the reciprocal product
                lim40_next = LIM_W'(prod_reg[PROD_W-1:CLAMP_SHIFT]);
                state_next = ST_INTEG;
            end
            ST_DIV_P:
            begin
                if (div_stat.done)
                begin
                    p_next          = sat_mag(div_stat.quot, neg_reg);
                    div_cmd.start   = 1'b1;
                    div_cmd.divisor = rr_reg;
                    neg_next        = prod_reg[PROD_W-1];
                    state_next      = ST_DIV_D;
                end
            end
            ST_DIV_D:
            begin
                if (div_stat.done)
                begin
                    d_next     = sat_mag(div_stat.quot, neg_reg);
                    state_next = ST_SUM;
                end
            end
            ST_INTEG:
            begin
                integral_next = int_clamped;
                i_next        = int_clamped;
                state_next    = ST_SUM;
            end
            ST_SUM:
            begin
                if (slot_free)
                begin
                    drive_next     = drive_clamped;
                    p_out_next     = p_reg;
                    i_out_next     = i_reg;
                    d_out_next     = d_reg;
                    out_valid_next = 1'b1;
                    last_err_next  = err_reg;
                    if (mode_reg == MODE_VEL)
                    begin
                        integral_next   = i_reg;
                        older_err_next  = last_err_reg;
                        last_drive_next = drive_clamped;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control, configuration and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            mode_reg       <= MODE_POS;
            p_gain_reg     <= '0;
            i_gain_reg     <= '0;
            d_gain_reg     <= '0;
            limit_reg      <= LIMIT_RESET;
            rate_reg       <= RATE_RESET;
            integral_reg   <= '0;
            last_err_reg   <= '0;
            older_err_reg  <= '0;
            last_drive_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            integral_reg   <= integral_next;
            last_err_reg   <= last_err_next;
            older_err_reg  <= older_err_next;
            last_drive_reg <= last_drive_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODE:   mode_reg   <= cfg_data[0];
                    CFG_P_GAIN: p_gain_reg <= cfg_data;
                    CFG_I_GAIN: i_gain_reg <= cfg_data;
                    CFG_D_GAIN: d_gain_reg <= cfg_data;
                    CFG_LIMIT:  limit_reg  <= cfg_data[LIM_W-1:0];
                    CFG_RATE:   rate_reg   <= cfg_data[RATE_W-1:0];
                    default:    mode_reg   <= mode_reg;
                endcase
            end
        end
    end

    // Hold work and output words
    always_ff @(posedge clk)
    begin
        err_reg   <= err_next;
        prod_reg  <= prod_next;
        p_reg     <= p_next;
        i_reg     <= i_next;
        d_reg     <= d_next;
        iinc_reg  <= iinc_next;
        lim40_reg <= lim40_next;
        rr_reg    <= rr_next;
        neg_reg   <= neg_next;
        drive_reg <= drive_next;
        p_out_reg <= p_out_next;
        i_out_reg <= i_out_next;
        d_out_reg <= d_out_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign p_term    = p_out_reg;
    assign i_term    = i_out_reg;
    assign d_term    = d_out_reg;

    // Divider is only started when free
    a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_cmd.start |-> !div_stat.busy)
        else $error("divider started while busy");

    // An accepted word enters the multiply sequence
    a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == ST_MUL_A))
        else $error("accepted word did not start the sequence");

    // A new result only comes from the summing step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_SUM))
        else $error("result appeared outside the summing step");

    // Positional integral stays inside its clamp
    a_int_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM && mode_reg == MODE_POS) |->
        (integral_reg <= $signed({1'b0, lim40_reg}) &&
         integral_reg >= -$signed({1'b0, lim40_reg})))
        else $error("integral outside clamp");

endmodule

### sim/pid_controller_two_form_test.sv
// ---------------------------------------------------------------------------
// pid_controller_two_form_test
// Self-checking bench for the two-form PID controller. A driver sends error
// words from a queue and predicts each result as the word is taken. A monitor
// compares every drive, P, I and D word against the oldest prediction. The
// run starts with a directed pass over the extreme values of the fields and
// the edge cases of both controller forms, then randomized phases, each under
// a fresh register setting, all but the last with random idle and stall bursts.
// ---------------------------------------------------------------------------
module pid_controller_two_form_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pcf_pkg::*;

    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     MAX_REPORTS    = 10;
    localparam longint S32_HI         = 64'sd2147483647;
    localparam longint S32_LO         = -64'sd2147483648;

    typedef struct {
        logic signed [DATA_W-1:0] err;
        logic                     clr;
    } sample_t;

    typedef struct {
        logic signed [DATA_W-1:0] drive;
        logic signed [DATA_W-1:0] p;
        logic signed [DATA_W-1:0] i;
        logic signed [DATA_W-1:0] d;
    } terms_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [DATA_W-1:0]        cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic signed [DATA_W-1:0] error     = '0;
    logic                     clear     = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] drive;
    logic signed [DATA_W-1:0] p_term;
    logic signed [DATA_W-1:0] i_term;
    logic signed [DATA_W-1:0] d_term;

    // Register shadow
    logic   vel_form = MODE_POS;
    longint kp       = 0;
    longint ki       = 0;
    longint kd       = 0;
    longint lim      = longint'(LIMIT_RESET);
    longint rate     = longint'(RATE_RESET);

    // Controller state shadow
    longint integ     = 0;
    longint last_err  = 0;
    longint older_err = 0;
    longint last_out  = 0;

    sample_t pending_samples[$];
    terms_t  due_outputs[$];

    int fault_count  = 0;
    int words_out    = 0;
    int send_gap     = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    bit steady_run   = 1'b0;

    pid_controller_two_form u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .error     (error),
        .clear     (clear),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive     (drive),
        .p_term    (p_term),
        .i_term    (i_term),
        .d_term    (d_term)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // Advance the controller shadow by one error word and return its outputs
    function automatic terms_t pid_step(input sample_t s);
        terms_t r;
        longint e;
        longint p;
        longint i;
        longint d;
        longint sum;
        longint lim40;
        longint rate_eff;
        longint diff1;
        longint dd;
        e = longint'(s.err);
        if (s.clr)
        begin
            integ    = 0;
            last_err = 0;
        end
        if (vel_form == MODE_POS)
        begin
            // Positional form: clamped integral at 0.4 of the limit
            lim40    = (lim * 2) / 5;
            p        = clip((e * kp) >>> Q_SHIFT, S32_LO, S32_HI);
            integ    = clip(integ + ((e * ki) >>> Q_SHIFT), -lim40, lim40);
            i        = integ;
            d        = clip(((e - last_err) * kd) >>> Q_SHIFT, S32_LO, S32_HI);
            sum      = clip(p + i + d, -lim, lim);
            last_err = e;
        end
        else
        begin
            // Velocity form: scaled differences and the I term added to the last drive
            rate_eff  = (rate == 0) ? 1 : rate;
            diff1     = e - last_err;
            dd        = clip(diff1 - (last_err - older_err), S32_LO, S32_HI);
            p         = clip((diff1 * kp) / (rate_eff <<< Q_SHIFT), S32_LO, S32_HI);
            i         = clip((e * ki) >>> Q_SHIFT, S32_LO, S32_HI);
            integ     = i;
            d         = clip((dd * kd) / ((rate_eff * rate_eff) <<< Q_SHIFT),
                             S32_LO, S32_HI);
            sum       = clip(last_out + p + i + d, -lim, lim);
            older_err = last_err;
            last_err  = e;
            last_out  = sum;
        end
        r.drive = sum[DATA_W-1:0];
        r.p     = p[DATA_W-1:0];
        r.i     = i[DATA_W-1:0];
        r.d     = d[DATA_W-1:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
                $display("word %0d %s: expected %h, got %h", words_out, name, want, got);
        end
    endfunction

    // Driver: predict each taken word, hold a stalled one, else idle or send
    always @(posedge clk or negedge rst_n)
    begin
        sample_t taken;
        sample_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            error    <= '0;
            clear    <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                taken.err = error;
                taken.clr = clear;
                due_outputs.push_back(pid_step(taken));
            end
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    nxt = pending_samples.pop_front();
                    in_valid <= 1'b1;
                    error    <= nxt.err;
                    clear    <= nxt.clr;
                    if (!steady_run && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 14);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each taken result, stall in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        terms_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_outputs.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("word %0d: result with none expected, drive %h",
                                 words_out, drive);
                end
                else
                begin
                    want = due_outputs.pop_front();
                    check_field("drive", want.drive, drive);
                    check_field("p_term", want.p, p_term);
                    check_field("i_term", want.i, i_term);
                    check_field("d_term", want.d, d_term);
                end
                words_out++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!steady_run && $urandom_range(0, 9) == 0)
            begin
                hold_left = $urandom_range(1, 14) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run when neither side moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("pid_controller_two_form: mismatch");
                $finish;
            end
        end
    end

    task automatic add_sample(input logic [DATA_W-1:0] e, input logic c);
        sample_t s;
        s.err = e;
        s.clr = c;
        pending_samples.push_back(s);
    endtask

    // Hold off until every queued word is sent and every result is back
    task automatic drain();
        do
            @(posedge clk);
        while (pending_samples.size() != 0 || in_valid || due_outputs.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_MODE:   vel_form = val[0];
            CFG_P_GAIN: kp = longint'(signed'(val));
            CFG_I_GAIN: ki = longint'(signed'(val));
            CFG_D_GAIN: kd = longint'(signed'(val));
            CFG_LIMIT:  lim = longint'(val[LIM_W-1:0]);
            CFG_RATE:   rate = longint'(val[RATE_W-1:0]);
            default:    ;
        endcase
    endtask

    task automatic set_regs(input logic m, input logic [DATA_W-1:0] gp,
                            input logic [DATA_W-1:0] gi, input logic [DATA_W-1:0] gd,
                            input logic [DATA_W-1:0] lm, input logic [DATA_W-1:0] rt);
        write_reg(CFG_MODE, {31'd0, m});
        write_reg(CFG_P_GAIN, gp);
        write_reg(CFG_I_GAIN, gi);
        write_reg(CFG_D_GAIN, gd);
        write_reg(CFG_LIMIT, lm);
        write_reg(CFG_RATE, rt);
    endtask

    function automatic logic [DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3, 4:    return $urandom();
            default: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_limit();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return {1'b0, 31'($urandom())};
            default: return 32'($urandom_range(1, 32'h0064_0000));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_rate();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'd1;
            2:       return 32'd65535;
            3, 4:    return 32'($urandom_range(1, 65535));
            default: return 32'($urandom_range(1, 200));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_error();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom();
            default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
        endcase
    endfunction

    initial
    begin
        int n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset setting: all gains zero
        add_sample(32'h7FFF_FFFF, 1'b0);
        add_sample(32'h8000_0000, 1'b0);
        drain();

        // Positional form, widest limit, saturating derivative
        set_regs(MODE_POS, 32'h0001_0000, 32'h0000_8000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'd100);
        add_sample(32'h0001_0000, 1'b0);
        add_sample(32'h7FFF_FFFF, 1'b0);
        add_sample(32'h8000_0000, 1'b0);
        add_sample(32'hFFFF_FFFF, 1'b1);
        add_sample(32'h0000_0000, 1'b0);
        add_sample(32'h0000_0001, 1'b0);
        drain();

        // Positional form with zero limit
        set_regs(MODE_POS, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd1);
        add_sample(32'h1234_5678, 1'b0);
        add_sample(32'h8000_0000, 1'b0);
        add_sample(32'h7FFF_FFFF, 1'b1);
        drain();

        // Velocity form, zero rate, wide second difference, clear
        set_regs(MODE_VEL, 32'h7FFF_FFFF, 32'h0001_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'd0);
        add_sample(32'h7FFF_FFFF, 1'b0);
        add_sample(32'h8000_0000, 1'b0);
        add_sample(32'h7FFF_FFFF, 1'b0);
        add_sample(32'h0002_0000, 1'b1);
        add_sample(32'h8000_0000, 1'b0);
        add_sample(32'h0000_0000, 1'b0);
        drain();

        // Velocity form, slowest rate, most negative gains
        set_regs(MODE_VEL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h0005_0000, 32'd65535);
        add_sample(32'h8000_0000, 1'b0);
        add_sample(32'h7FFF_FFFF, 1'b0);
        add_sample(32'hFFFF_0000, 1'b0);
        drain();

        // Velocity form with zero limit
        set_regs(MODE_VEL, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'd0, 32'd1);
        add_sample(32'h0001_0000, 1'b0);
        add_sample(32'h7FFF_FFFF, 1'b0);
        drain();

        // Random phases, each under a fresh setting; the last runs without idling
        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph == 11)
                steady_run = 1'b1;
            set_regs($urandom_range(0, 1) ? MODE_VEL : MODE_POS, pick_gain(), pick_gain(),
                     pick_gain(), pick_limit(), pick_rate());
            n = $urandom_range(70, 110);
            for (int k = 0; k < n; k++)
            begin
                add_sample(pick_error(), $urandom_range(0, 9) == 0);
                if ($urandom_range(0, 39) == 0)
                    drain();
            end
            drain();
        end

        repeat (120) @(posedge clk);
        if (fault_count == 0 && due_outputs.size() == 0)
            $display("pid_controller_two_form: match");
        else
            $display("pid_controller_two_form: mismatch");
        $finish;
    end

endmodule

### filelist.f
design/pcf_pkg.sv
design/pcf_div.sv
design/pid_controller_two_form.sv
sim/pid_controller_two_form_test.sv
